### hw/rtl/mexp_pkg.sv
// Shared constants, types and sequencer states for the modular exponentiation block.
package mexp_pkg;

    localparam int BASE_W           = 32;
    localparam int EXP_W            = 31;
    localparam int MOD_W            = 31;
    localparam int RES_W            = 31;
    localparam int MOD_BITS_DEFAULT = 31;
    localparam int CNT_W            = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_NEXT,
        S_MUL,
        S_SQR,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } mm_cmd_t;

endpackage

### hw/rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block with its output register.
// Operation: the base is first reduced modulo the modulus; then, for each exponent bit from the
// least significant, a dispatch step, a multiply when the bit is set and a square, which is
// skipped after the multiply for the most significant set bit. MW is the modulus width (31 by default).
// Items are handled one at a time: a new input is accepted only while the sequencer is idle.
// Reset: rst_n clears the sequencer state and the output valid flag asynchronously.
module modular_exponentiation #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mexp_pkg::BASE_W-1:0]  base,
    input  logic [mexp_pkg::EXP_W-1:0]   exponent,
    input  logic [mexp_pkg::MOD_W-1:0]   modulus,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [mexp_pkg::RES_W-1:0]   power_residue
);
    import mexp_pkg::*;

    // The sequencer holds a finished result until the output register is free, so a new
    // input transfer can start as soon as the result has moved here, even while the
    // downstream side is still stalling the previous one.
    logic             res_valid;
    logic             res_take;
    logic [RES_W-1:0] res;

    logic             out_valid_reg;
    logic [RES_W-1:0] power_residue_reg;

    mexp_seq #(
        .MOD_BITS(MOD_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base      (base),
        .exponent  (exponent),
        .modulus   (modulus),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // The output register can load when it is empty or its content leaves in this cycle.
    assign res_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // The payload register changes only when the register is free, so a stalled result holds.
    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            power_residue_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign power_residue = power_residue_reg;

endmodule

### hw/rtl/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: r = (a * y) mod m, one multiplier bit per cycle.
module mexp_mulmod #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEFAULT
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  mexp_pkg::mm_cmd_t                             cmd,
    input  logic [((MOD_BITS < mexp_pkg::MOD_W) ? MOD_BITS : mexp_pkg::MOD_W)-1:0] a,
    input  logic [mexp_pkg::BASE_W-1:0]                   y,
    input  logic [((MOD_BITS < mexp_pkg::MOD_W) ? MOD_BITS : mexp_pkg::MOD_W)-1:0] m,
    output logic                                          done,
    output logic [((MOD_BITS < mexp_pkg::MOD_W) ? MOD_BITS : mexp_pkg::MOD_W)-1:0] r
);
    import mexp_pkg::*;

    localparam int MW = (MOD_BITS < MOD_W) ? MOD_BITS : MOD_W;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MW-1:0]    a_reg;
    logic [BASE_W-1:0] y_reg;
    logic [MW-1:0]    r_reg;
    logic [MW-1:0]    r_next;

    logic [MW:0] dbl;
    logic [MW:0] red;
    logic [MW:0] sum;
    logic [MW:0] m_ext;

    // One step: double the partial result, reduce, add the multiplicand if the bit is set,
    // reduce again. Each reduction needs at most one subtraction because both terms stay below m.
    always_comb
    begin
        m_ext  = {1'b0, m};
        dbl    = {r_reg, 1'b0};
        red    = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum    = red + (y_reg[BASE_W-1] ? {1'b0, a_reg} : {(MW+1){1'b0}});
        r_next = (sum >= m_ext) ? MW'(sum - m_ext) : MW'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg <= a;
            y_reg <= y;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            y_reg <= {y_reg[BASE_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign r    = r_reg;

endmodule

### hw/rtl/mexp_seq.sv
// Square-and-multiply sequencer that drives the shared modular multiplier.
module mexp_seq #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [mexp_pkg::BASE_W-1:0]  base,
    input  logic [mexp_pkg::EXP_W-1:0]   exponent,
    input  logic [mexp_pkg::MOD_W-1:0]   modulus,
    output logic                         res_valid,
    input  logic                         res_take,
    output logic [mexp_pkg::RES_W-1:0]   res
);
    import mexp_pkg::*;

    localparam int MW = (MOD_BITS < MOD_W) ? MOD_BITS : MOD_W;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [MW-1:0]    m_reg;
    logic [MW-1:0]    b_reg;
    logic [MW-1:0]    acc_reg;
    logic [EXP_W-1:0] e_reg;

    logic [MW-1:0]     m_in;
    logic              in_accept;
    logic              e_last;
    mm_cmd_t           cmd;
    logic [MW-1:0]     mm_a;
    logic [BASE_W-1:0] mm_y;
    logic              mm_done;
    logic [MW-1:0]     mm_r;

    assign m_in      = modulus[MW-1:0];
    assign in_accept = in_valid && !in_stall;
    assign e_last    = (e_reg[EXP_W-1:1] == '0);

    mexp_mulmod #(
        .MOD_BITS(MOD_BITS)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .a     (mm_a),
        .y     (mm_y),
        .m     (m_reg),
        .done  (mm_done),
        .r     (mm_r)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (m_in == '0) ? S_DONE : S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (mm_done)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (e_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (e_reg[0])
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                if (mm_done)
                begin
                    state_next = e_last ? S_DONE : S_SQR;
                end
            end
            S_SQR:
            begin
                if (mm_done)
                begin
                    state_next = S_NEXT;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The reduction of the base runs through the multiplier as 1 * base, scanning all base bits.
    always_comb
    begin
        in_stall   = (state_reg != S_IDLE);
        res_valid  = (state_reg == S_DONE);
        cmd.start  = 1'b0;
        cmd.nbits  = CNT_W'(MW);
        mm_a       = b_reg;
        mm_y       = {b_reg, {(BASE_W-MW){1'b0}}};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (m_in != '0))
                begin
                    cmd.start = 1'b1;
                    cmd.nbits = CNT_W'(BASE_W);
                    mm_a      = MW'(1);
                    mm_y      = base;
                end
            end
            S_NEXT:
            begin
                if (e_reg != '0)
                begin
                    cmd.start = 1'b1;
                    if (e_reg[0])
                    begin
                        mm_a = acc_reg;
                    end
                end
            end
            S_MUL:
            begin
                if (mm_done && !e_last)
                begin
                    cmd.start = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    m_reg   <= m_in;
                    e_reg   <= exponent;
                    acc_reg <= (m_in == '0) ? MW'(0) : MW'(1);
                end
            end
            S_REDUCE:
            begin
                if (mm_done)
                begin
                    b_reg <= mm_r;
                end
            end
            S_MUL:
            begin
                if (mm_done)
                begin
                    acc_reg <= mm_r;
                end
            end
            S_SQR:
            begin
                if (mm_done)
                begin
                    b_reg <= mm_r;
                    e_reg <= {1'b0, e_reg[EXP_W-1:1]};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res = RES_W'(acc_reg);

endmodule
